>>> src/gcpd_pkg.sv
package gcpd_pkg;

   // Default width of the column and row accumulators.
   localparam int MAX_CODE_BITS_DEFAULT = 12;

   // Depth of the queue between the classifying front and the decoding back.
   localparam int QUEUE_DEPTH = 4;

   localparam int SAMPLE_W    = 8;
   localparam int THRESHOLD_W = 8;
   localparam int BITS_W      = 4;
   localparam int OFFSET_W    = 12;
   localparam int SIZE_W      = 13;
   localparam int COORD_W     = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHADOW_THRESHOLD   = 3'd0,
      CSR_CONTRAST_THRESHOLD = 3'd1,
      CSR_COLUMN_BITS        = 3'd2,
      CSR_ROW_BITS           = 3'd3,
      CSR_COLUMN_OFFSET      = 3'd4,
      CSR_ROW_OFFSET         = 3'd5,
      CSR_PROJECTOR_WIDTH    = 3'd6,
      CSR_PROJECTOR_HEIGHT   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [THRESHOLD_W-1:0] shadow_threshold;
      logic [THRESHOLD_W-1:0] contrast_threshold;
      logic [BITS_W-1:0]      column_bits;
      logic [BITS_W-1:0]      row_bits;
      logic [OFFSET_W-1:0]    column_offset;
      logic [OFFSET_W-1:0]    row_offset;
      logic [SIZE_W-1:0]      projector_width;
      logic [SIZE_W-1:0]      projector_height;
   } cfg_type;

   // One classified sample pair as it travels through the queue.
   typedef struct packed {
      logic start;         // reference pair, restarts the pixel
      logic pattern_gt;    // Gray bit: pattern brighter than inverse
      logic low_contrast;  // pattern and inverse too close together
      logic lit;           // white minus black above the shadow threshold
   } item_type;

endpackage

>>> src/gcpd_if.sv
interface gcpd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         start_of_pixel;
   logic [gcpd_pkg::SAMPLE_W-1:0] first_sample;
   logic [gcpd_pkg::SAMPLE_W-1:0] second_sample;

   modport source (output valid, start_of_pixel, first_sample, second_sample, input ready);
   modport sink   (input valid, start_of_pixel, first_sample, second_sample, output ready);
endinterface

interface gcpd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gcpd_pkg::COORD_W-1:0] column;
   logic [gcpd_pkg::COORD_W-1:0] row;
   logic                         shadowed;
   logic                         decode_error;

   modport source (output valid, column, row, shadowed, decode_error, input ready);
   modport sink   (input valid, column, row, shadowed, decode_error, output ready);
endinterface

>>> src/gcpd_front.sv
module gcpd_front (
   gcpd_req_if.sink            req_chan,
   input  gcpd_pkg::cfg_type   cfg,
   input  logic                queue_full,
   output logic                push,
   output gcpd_pkg::item_type  item
);

   logic [gcpd_pkg::SAMPLE_W-1:0]   abs_diff;
   logic [gcpd_pkg::SAMPLE_W+1:0]   black_plus_thr;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   always_comb begin
      if (req_chan.first_sample > req_chan.second_sample) begin
         abs_diff = req_chan.first_sample - req_chan.second_sample;
      end else begin
         abs_diff = req_chan.second_sample - req_chan.first_sample;
      end
      black_plus_thr = {2'b00, req_chan.second_sample} + {2'b00, cfg.shadow_threshold};

      item.start        = req_chan.start_of_pixel;
      item.pattern_gt   = req_chan.first_sample > req_chan.second_sample;
      item.low_contrast = abs_diff < cfg.contrast_threshold;
      item.lit          = {2'b00, req_chan.first_sample} > black_plus_thr;
   end

endmodule

>>> src/gcpd_queue.sv
module gcpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gcpd_pkg::item_type  push_item,
   input  logic                pop,
   output gcpd_pkg::item_type  head_item,
   output logic                full,
   output logic                empty
);

   localparam int PTR_W = (gcpd_pkg::QUEUE_DEPTH > 1) ? $clog2(gcpd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(gcpd_pkg::QUEUE_DEPTH + 1);

   gcpd_pkg::item_type   entry_ff [gcpd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = count_ff == CNT_W'(gcpd_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(gcpd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(gcpd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The front must never offer an entry to a full queue, nor the back take from an empty one.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue written while full");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("queue read while empty");
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a write");

endmodule

>>> src/gcpd_back.sv
module gcpd_back #(
   parameter int MAX_CODE_BITS = gcpd_pkg::MAX_CODE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  gcpd_pkg::cfg_type   cfg,
   input  logic                queue_empty,
   input  gcpd_pkg::item_type  head_item,
   output logic                pop,
   gcpd_rsp_if.source          rsp_chan
);

   localparam int ACC_W   = MAX_CODE_BITS;
   localparam int PHASE_W = $clog2(2 * MAX_CODE_BITS + 1);
   localparam int DIFF_W  = ((ACC_W > gcpd_pkg::SIZE_W) ? ACC_W : gcpd_pkg::SIZE_W) + 1;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               running_ff, running_in;
   logic [ACC_W-1:0]   col_acc_ff, col_acc_in;
   logic [ACC_W-1:0]   row_acc_ff, row_acc_in;
   logic               error_ff, error_in;
   logic               shadow_ff, shadow_in;

   logic                          out_valid_ff, out_valid_in;
   logic [gcpd_pkg::COORD_W-1:0]  out_column_ff, out_column_in;
   logic [gcpd_pkg::COORD_W-1:0]  out_row_ff, out_row_in;
   logic                          out_shadow_ff, out_shadow_in;
   logic                          out_error_ff, out_error_in;

   logic [PHASE_W-1:0] col_bits_eff;
   logic [PHASE_W-1:0] row_bits_eff;
   logic               bin_bit;
   logic               last_pair;
   logic               err_total;
   logic [DIFF_W-1:0]  col_adj;
   logic [DIFF_W-1:0]  row_adj;
   logic               col_bad;
   logic               row_bad;

   function automatic logic [PHASE_W-1:0] eff_bits(input logic [gcpd_pkg::BITS_W-1:0] b);
      logic [PHASE_W-1:0] r;
      if (b == '0) begin
         r = PHASE_W'(1);
      end else if (int'(b) > MAX_CODE_BITS) begin
         r = PHASE_W'(MAX_CODE_BITS);
      end else begin
         r = PHASE_W'(b);
      end
      return r;
   endfunction

   // An entry leaves the queue whenever the result register can take a result.
   assign pop = !queue_empty && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      col_bits_eff = eff_bits(cfg.column_bits);
      row_bits_eff = eff_bits(cfg.row_bits);
      bin_bit      = running_ff ^ head_item.pattern_gt;
      last_pair    = phase_ff >= (col_bits_eff + row_bits_eff);

      phase_in   = phase_ff;
      running_in = running_ff;
      col_acc_in = col_acc_ff;
      row_acc_in = row_acc_ff;
      error_in   = error_ff;
      shadow_in  = shadow_ff;

      if (pop) begin
         if (head_item.start) begin
            shadow_in  = !head_item.lit;
            error_in   = 1'b0;
            running_in = 1'b0;
            col_acc_in = '0;
            row_acc_in = '0;
            phase_in   = PHASE_W'(1);
         end else if (phase_ff != '0) begin
            error_in = error_ff | head_item.low_contrast;
            if (phase_ff <= col_bits_eff) begin
               col_acc_in = (col_acc_ff << 1) | ACC_W'(bin_bit);
               running_in = (phase_ff == col_bits_eff) ? 1'b0 : bin_bit;
            end else begin
               row_acc_in = (row_acc_ff << 1) | ACC_W'(bin_bit);
               running_in = bin_bit;
            end
            if (last_pair) begin
               phase_in   = '0;
               running_in = 1'b0;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
      end

      col_adj   = DIFF_W'(col_acc_in) - DIFF_W'(cfg.column_offset);
      row_adj   = DIFF_W'(row_acc_in) - DIFF_W'(cfg.row_offset);
      col_bad   = col_adj[DIFF_W-1] || (col_adj >= DIFF_W'(cfg.projector_width));
      row_bad   = row_adj[DIFF_W-1] || (row_adj >= DIFF_W'(cfg.projector_height));
      err_total = error_in || col_bad || row_bad;

      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      out_shadow_in = out_shadow_ff;
      out_error_in  = out_error_ff;
      if (pop && !head_item.start && (phase_ff != '0) && last_pair) begin
         out_valid_in  = 1'b1;
         out_column_in = err_total ? '0 : col_adj[gcpd_pkg::COORD_W-1:0];
         out_row_in    = err_total ? '0 : row_adj[gcpd_pkg::COORD_W-1:0];
         out_shadow_in = shadow_in;
         out_error_in  = err_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         running_ff   <= 1'b0;
         col_acc_ff   <= '0;
         row_acc_ff   <= '0;
         error_ff     <= 1'b0;
         shadow_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         running_ff   <= running_in;
         col_acc_ff   <= col_acc_in;
         row_acc_ff   <= row_acc_in;
         error_ff     <= error_in;
         shadow_ff    <= shadow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_column_ff <= out_column_in;
      out_row_ff    <= out_row_in;
      out_shadow_ff <= out_shadow_in;
      out_error_ff  <= out_error_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.column       = out_column_ff;
   assign rsp_chan.row          = out_row_ff;
   assign rsp_chan.shadowed     = out_shadow_ff;
   assign rsp_chan.decode_error = out_error_ff;

   // A failed decode always reports a zero position.
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_error_ff) |-> (out_column_ff == '0 && out_row_ff == '0))
      else $error("decode error reported with a non-zero position");
   // Delivering a result returns the sequencer to waiting for a reference pair.
   a_idle_after_result : assert property (@(posedge clock) disable iff (reset)
      (pop && !head_item.start && phase_ff != '0 && last_pair) |=> phase_ff == '0)
      else $error("phase not cleared after the last pair");

endmodule

>>> src/gray_code_pixel_decoder_unit.sv
// Gray-code structured-light pixel decoder. Each camera pixel is streamed in as sample-pair
// transactions on req_chan: a reference pair (start_of_pixel high, white then black), then
// column_bits column pattern/inverse pairs and row_bits row pairs, most significant first.
// After the last row pair one result transaction appears on rsp_chan carrying the decoded
// projector column and row (offsets removed, range checked against the projector size, both
// zero when decode_error is set) and the shadow flag. Pairs arriving while no pixel is open
// are dropped, and a new reference pair abandons any pixel in progress. The block takes one
// transaction per clock cycle while the queue is not full: the front stage classifies a pair in
// the cycle it is accepted, a four-entry queue holds classified pairs, and the back stage
// retires one pair per cycle into the result register while that register can take a result.
// A result is visible on rsp_chan in the cycle after its last pair leaves the queue.
// Configuration registers are written through the csr_ port and must only be changed while
// no pixel is open and the pipeline has drained.
module gray_code_pixel_decoder_unit #(
   parameter int MAX_CODE_BITS = gcpd_pkg::MAX_CODE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   gcpd_req_if.sink                            req_chan,
   gcpd_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [gcpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gcpd_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // Configuration register file. Each write takes the low bits of the write data that
   // fit the addressed register.
   gcpd_pkg::cfg_type cfg_ff, cfg_in;

   // Classified transaction passing from the front stage into the queue.
   gcpd_pkg::item_type front_item;
   gcpd_pkg::item_type head_item;
   logic               front_push;
   logic               queue_pop;
   logic               queue_full;
   logic               queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (gcpd_pkg::csr_index_type'(csr_index))
            gcpd_pkg::CSR_SHADOW_THRESHOLD: begin
               cfg_in.shadow_threshold = csr_write_data[gcpd_pkg::THRESHOLD_W-1:0];
            end
            gcpd_pkg::CSR_CONTRAST_THRESHOLD: begin
               cfg_in.contrast_threshold = csr_write_data[gcpd_pkg::THRESHOLD_W-1:0];
            end
            gcpd_pkg::CSR_COLUMN_BITS: begin
               cfg_in.column_bits = csr_write_data[gcpd_pkg::BITS_W-1:0];
            end
            gcpd_pkg::CSR_ROW_BITS: begin
               cfg_in.row_bits = csr_write_data[gcpd_pkg::BITS_W-1:0];
            end
            gcpd_pkg::CSR_COLUMN_OFFSET: begin
               cfg_in.column_offset = csr_write_data[gcpd_pkg::OFFSET_W-1:0];
            end
            gcpd_pkg::CSR_ROW_OFFSET: begin
               cfg_in.row_offset = csr_write_data[gcpd_pkg::OFFSET_W-1:0];
            end
            gcpd_pkg::CSR_PROJECTOR_WIDTH: begin
               cfg_in.projector_width = csr_write_data[gcpd_pkg::SIZE_W-1:0];
            end
            gcpd_pkg::CSR_PROJECTOR_HEIGHT: begin
               cfg_in.projector_height = csr_write_data[gcpd_pkg::SIZE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Reset values give a 1024 by 768 projector with ten-bit codes and no thresholds.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shadow_threshold   <= '0;
         cfg_ff.contrast_threshold <= '0;
         cfg_ff.column_bits        <= gcpd_pkg::BITS_W'(10);
         cfg_ff.row_bits           <= gcpd_pkg::BITS_W'(10);
         cfg_ff.column_offset      <= '0;
         cfg_ff.row_offset         <= '0;
         cfg_ff.projector_width    <= gcpd_pkg::SIZE_W'(1024);
         cfg_ff.projector_height   <= gcpd_pkg::SIZE_W'(768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front stage compares each pair against the thresholds as it is accepted.
   gcpd_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (front_push),
      .item       (front_item)
   );

   // The queue lets the front keep accepting while the result register is held.
   gcpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .pop       (queue_pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // The back stage sequences the pixel, accumulates the binary code and finishes it.
   gcpd_back #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_item   (head_item),
      .pop         (queue_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
